// ===== src/llds_pkg.sv =====
// Package: shared types, register codes, constants and the saturation function.
`default_nettype none
package llds_pkg;

    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN   = 2'd3;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [38:0] R_CLAMP   = 39'h40_0000_0000;
    localparam logic [63:0] POS_LIMIT = 64'd2147483647;
    localparam logic [63:0] NEG_LIMIT = 64'd2147483648;
    localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic               inv;
        logic               pos;
        logic               xbad;
        logic               zero_err;
        logic               iperr;
        logic               neg;
        logic               dpos;
        logic [31:0]        av;
        logic [32:0]        xu;
        logic [5:0]         px;
        logic [5:0]         pk;
        logic [30:0]        mx;
        logic [30:0]        mk;
        logic [31:0]        fx;
        logic [31:0]        fk;
        logic [63:0]        dvd;
        logic [30:0]        rem;
        logic [38:0]        quo;
        logic               qbig;
        logic [37:0]        ad;
        logic [38:0]        rm;
        logic [37:0]        lnq;
        logic [39:0]        zm;
        logic signed [8:0]  ip;
        logic [31:0]        fr;
        logic [29:0]        u;
        logic [30:0]        term;
        logic [31:0]        sum;
        logic [60:0]        ep;
        logic [62:0]        pp;
        logic [63:0]        val;
        logic [63:0]        mag;
    } t_item;

    typedef struct packed {
        logic        err;
        logic [31:0] value;
    } t_res;

    function automatic t_res f_sat(input logic neg, input logic [63:0] mag);
        t_res r;
        r.err = 1'b0;
        if (neg) begin
            if (mag > NEG_LIMIT) begin
                r.err   = 1'b1;
                r.value = INT_MIN;
            end else begin
                r.value = ~mag[31:0] + 32'd1;
            end
        end else begin
            if (mag > POS_LIMIT) begin
                r.err   = 1'b1;
                r.value = INT_MAX;
            end else begin
                r.value = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/llds_in_if.sv =====
// Interface: input item channel with valid/ready handshake.
`default_nettype none
interface llds_in_if;
    import llds_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [VALUE_W-1:0] value_in;
    modport source (output valid, mode, value_in, input ready);
    modport sink (input valid, mode, value_in, output ready);
endinterface
`default_nettype wire

// ===== src/llds_out_if.sv =====
// Interface: result item channel with valid/ready handshake.
`default_nettype none
interface llds_out_if;
    import llds_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value_out;
    logic                      range_error;
    modport source (output valid, value_out, range_error, input ready);
    modport sink (input valid, value_out, range_error, output ready);
endinterface
`default_nettype wire

// ===== src/log_linear_depth_scaler.sv =====
// Throughput: one item per cycle while the output is not stalled; the pipeline length is set
// by the 64-step restoring divider followed by the exponential series, two stages per term.
// A stall at the output freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module log_linear_depth_scaler #(
    parameter int FRAC_BITS          = 16,
    parameter int LOG_EXP_ITERATIONS = 24
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [llds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [llds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    llds_in_if.sink                         i_req,
    llds_out_if.source                      o_rsp
);
    import llds_pkg::*;

    localparam int ITER      = LOG_EXP_ITERATIONS;
    localparam int DIV_STEPS = 64;
    localparam int S_NORM    = 1;
    localparam int S_DIV0    = 2;
    localparam int S_P0      = S_DIV0 + DIV_STEPS;
    localparam int S_P1      = S_P0 + 1;
    localparam int S_P2      = S_P1 + 1;
    localparam int S_P3      = S_P2 + 1;
    localparam int S_E0      = S_P3 + 1;
    localparam int S_Q0      = S_E0 + 2 * ITER;
    localparam int S_Q1      = S_Q0 + 1;
    localparam int S_Q2      = S_Q1 + 1;
    localparam int NST       = S_Q2 + 1;

    logic                  r_depth_mode;
    logic [CFG_DATA_W-1:0] r_log_offset;
    logic [CFG_DATA_W-1:0] r_log_gain;
    logic [CFG_DATA_W-1:0] r_lin_gain;

    t_item          r_st [NST];
    t_item          n_st [NST];
    logic [NST-1:0] r_vld;
    t_res           r_out;
    t_res           n_out;
    logic           r_out_vld;
    logic           w_en;
    logic [30:0]    w_dvs;
    logic           w_lin;

    function automatic logic [5:0] f_msb(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int b = 1; b < 33; b++) begin
            if (v[b]) p = 6'(b);
        end
        return p;
    endfunction

    function automatic logic [30:0] f_norm(input logic [32:0] v, input logic [5:0] p);
        logic [32:0] s;
        s = (p <= 6'd30) ? (v << (6'd30 - p)) : (v >> (p - 6'd30));
        return s[30:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= 1'b1;
            r_log_offset <= 31'd3276800;
            r_log_gain   <= 31'd819200;
            r_lin_gain   <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEPTH_MODE: r_depth_mode <= i_cfg_data[0];
                CFG_LOG_OFFSET: r_log_offset <= i_cfg_data;
                CFG_LOG_GAIN:   r_log_gain   <= i_cfg_data;
                CFG_LIN_GAIN:   r_lin_gain   <= i_cfg_data;
            endcase
        end
    end

    assign w_lin       = r_depth_mode;
    assign w_dvs       = w_lin ? r_lin_gain : r_log_gain;
    assign w_en        = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_en;

    always_comb begin
        logic signed [32:0] x;
        x = {i_req.value_in[31], i_req.value_in} + signed'({2'b00, r_log_offset});
        n_st[0]          = '0;
        n_st[0].inv      = i_req.mode;
        n_st[0].pos      = !i_req.value_in[31] && (|i_req.value_in);
        n_st[0].av       = i_req.value_in[31] ? (~i_req.value_in + 32'd1) : i_req.value_in;
        n_st[0].xbad     = x[32] || (x == '0);
        n_st[0].xu       = x;
        n_st[0].zero_err = w_lin ? (r_lin_gain == '0)
                                 : ((r_log_offset == '0) || (r_log_gain == '0));
    end

    for (genvar i = 1; i < NST; i++) begin : g_st
        if (i == S_NORM) begin : g_norm
            always_comb begin
                logic [62:0] lp;
                n_st[i]     = r_st[i-1];
                n_st[i].px  = f_msb(r_st[i-1].xu);
                n_st[i].pk  = f_msb({2'b00, r_log_offset});
                n_st[i].mx  = f_norm(r_st[i-1].xu, n_st[i].px);
                n_st[i].mk  = f_norm({2'b00, r_log_offset}, n_st[i].pk);
                n_st[i].dvd = w_lin ? (64'(r_st[i-1].av) << FRAC_BITS)
                                    : {r_st[i-1].av, 32'd0};
                lp          = r_st[i-1].av * r_lin_gain;
                n_st[i].mag = {1'b0, lp};
            end
        end else if (i >= S_DIV0 && i < S_P0) begin : g_div
            localparam int  J      = i - S_DIV0;
            localparam bit  DO_LOG = J < ITER;
            localparam int  FB     = (J < 32) ? 31 - J : 0;
            always_comb begin
                logic [31:0] r2;
                logic        ge;
                logic [61:0] sqx;
                logic [61:0] sqk;
                n_st[i]      = r_st[i-1];
                r2           = {r_st[i-1].rem, r_st[i-1].dvd[63]};
                ge           = r2 >= {1'b0, w_dvs};
                n_st[i].rem  = ge ? 31'(r2 - {1'b0, w_dvs}) : r2[30:0];
                n_st[i].dvd  = {r_st[i-1].dvd[62:0], 1'b0};
                n_st[i].qbig = r_st[i-1].qbig | r_st[i-1].quo[38];
                n_st[i].quo  = {r_st[i-1].quo[37:0], ge};
                sqx          = r_st[i-1].mx * r_st[i-1].mx;
                sqk          = r_st[i-1].mk * r_st[i-1].mk;
                if (DO_LOG) begin
                    if (sqx[61]) begin
                        n_st[i].mx     = sqx[61:31];
                        n_st[i].fx[FB] = 1'b1;
                    end else begin
                        n_st[i].mx = sqx[60:30];
                    end
                    if (sqk[61]) begin
                        n_st[i].mk     = sqk[61:31];
                        n_st[i].fk[FB] = 1'b1;
                    end else begin
                        n_st[i].mk = sqk[60:30];
                    end
                end
            end
        end else if (i == S_P0) begin : g_p0
            always_comb begin
                logic signed [38:0] diff;
                n_st[i]      = r_st[i-1];
                diff         = signed'({1'b0, r_st[i-1].px, r_st[i-1].fx})
                             - signed'({1'b0, r_st[i-1].pk, r_st[i-1].fk});
                n_st[i].dpos = !diff[38] && (|diff);
                n_st[i].ad   = diff[38] ? 38'(-diff) : diff[37:0];
                n_st[i].rm   = (r_st[i-1].qbig || (r_st[i-1].quo > R_CLAMP)) ? R_CLAMP
                                                                            : r_st[i-1].quo;
                if (w_lin) begin
                    n_st[i].neg = r_st[i-1].pos;
                    if (r_st[i-1].inv) begin
                        n_st[i].mag = r_st[i-1].qbig ? '1 : 64'(r_st[i-1].quo);
                    end else begin
                        n_st[i].mag = r_st[i-1].mag >> FRAC_BITS;
                    end
                end
            end
        end else if (i == S_P1) begin : g_p1
            always_comb begin
                logic [69:0] pa;
                logic [71:0] pb;
                n_st[i]     = r_st[i-1];
                pa          = r_st[i-1].ad * LN2_Q32;
                pb          = r_st[i-1].rm * LOG2E_Q32;
                n_st[i].lnq = pa[69:32];
                n_st[i].zm  = pb[71:32];
            end
        end else if (i == S_P2) begin : g_p2
            always_comb begin
                logic [68:0]       pc;
                logic signed [8:0] ipm;
                logic [31:0]       f;
                n_st[i] = r_st[i-1];
                pc      = r_st[i-1].lnq * r_log_gain;
                if (!w_lin && !r_st[i-1].inv) begin
                    n_st[i].mag = 64'(pc[68:32]);
                    n_st[i].neg = r_st[i-1].dpos;
                end
                ipm = signed'({1'b0, r_st[i-1].zm[39:32]});
                f   = r_st[i-1].zm[31:0];
                if (!r_st[i-1].pos || (r_st[i-1].zm == '0)) begin
                    n_st[i].ip = ipm;
                    n_st[i].fr = f;
                end else if (f == '0) begin
                    n_st[i].ip = -ipm;
                    n_st[i].fr = f;
                end else begin
                    n_st[i].ip = -ipm - 9'sd1;
                    n_st[i].fr = ~f + 32'd1;
                end
                n_st[i].iperr = n_st[i].ip >= 9'sd33;
            end
        end else if (i == S_P3) begin : g_p3
            always_comb begin
                logic [63:0] pd;
                n_st[i]      = r_st[i-1];
                pd           = r_st[i-1].fr * LN2_Q32;
                n_st[i].u    = pd[63:34];
                n_st[i].term = 31'h4000_0000;
                n_st[i].sum  = 32'h4000_0000;
            end
        end else if (i >= S_E0 && i < S_Q0) begin : g_exp
            localparam int E  = i - S_E0;
            localparam int KN = E / 2 + 1;
            // The scaled term stays below 2^30, so a 35-bit reciprocal gives the exact quotient.
            localparam logic [35:0] KM = 36'(((64'd1 << 35) + 64'(KN) - 64'd1) / 64'(KN));
            if ((E % 2) == 0) begin : g_mul
                always_comb begin
                    n_st[i]    = r_st[i-1];
                    n_st[i].ep = r_st[i-1].term * r_st[i-1].u;
                end
            end else begin : g_acc
                always_comb begin
                    logic [65:0] qp;
                    logic [30:0] t;
                    n_st[i]      = r_st[i-1];
                    qp           = {36'd0, r_st[i-1].ep[59:30]} * {30'd0, KM};
                    t            = qp[65:35];
                    n_st[i].term = t;
                    n_st[i].sum  = r_st[i-1].sum + 32'(t);
                end
            end
        end else if (i == S_Q0) begin : g_q0
            always_comb begin
                n_st[i]    = r_st[i-1];
                n_st[i].pp = r_log_offset * r_st[i-1].sum;
            end
        end else if (i == S_Q1) begin : g_q1
            always_comb begin
                logic signed [9:0] sh;
                logic [9:0]        nsh;
                logic [63:0]       p64;
                n_st[i] = r_st[i-1];
                sh      = 10'sd30 - 10'(r_st[i-1].ip);
                nsh     = 10'(-sh);
                p64     = {1'b0, r_st[i-1].pp};
                if (sh <= 10'sd0) begin
                    n_st[i].val = p64 << nsh[5:0];
                end else if (sh >= 10'sd64) begin
                    n_st[i].val = '0;
                end else begin
                    n_st[i].val = p64 >> sh[5:0];
                end
            end
        end else begin : g_q2
            always_comb begin
                logic [63:0] k1;
                n_st[i] = r_st[i-1];
                k1      = 64'(r_log_offset);
                if (!w_lin && r_st[i-1].inv) begin
                    if (r_st[i-1].val >= k1) begin
                        n_st[i].mag = r_st[i-1].val - k1;
                        n_st[i].neg = 1'b0;
                    end else begin
                        n_st[i].mag = k1 - r_st[i-1].val;
                        n_st[i].neg = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        t_item q;
        q = r_st[NST-1];
        if (q.zero_err) begin
            n_out.err   = 1'b1;
            n_out.value = '0;
        end else if (!w_lin && ((!q.inv && q.xbad) || (q.inv && q.iperr))) begin
            n_out.err   = 1'b1;
            n_out.value = INT_MAX;
        end else begin
            n_out = f_sat(q.neg, q.mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NST-2:0], i_req.valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.value_out   = r_out.value;
    assign o_rsp.range_error = r_out.err;

endmodule
`default_nettype wire

// ===== src/llds_chk.sv =====
// Checker: port-level assertions on the depth scaler, with its bind statement.
`default_nettype none
module llds_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_value,
    input wire        i_out_err
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_err))
        else $error("Stalled result item changed or vanished.");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("Input taken while the pipeline is frozen.");

    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input refused with the output stage empty.");

    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_ready))
        else $error("Input ready unknown while an item is offered.");

endmodule

bind log_linear_depth_scaler llds_chk u_llds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_value (o_rsp.value_out),
    .i_out_err   (o_rsp.range_error)
);
`default_nettype wire

// ===== test/tb_log_linear_depth_scaler.sv =====
// Testbench: drives depth items and register settings, predicts and checks every result.
`timescale 1ns / 100ps
module tb_log_linear_depth_scaler;
    import llds_pkg::*;

    localparam int ITER_N       = 24;
    localparam int LAT_CYCLES   = 121;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 70;
    localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

    class depth_scoreboard;
        bit          lin_mode;
        bit [30:0]   k1;
        bit [30:0]   k2;
        bit [30:0]   g;
        bit [31:0]   pending_val[$];
        bit          pending_err[$];
        int          mismatches;

        function new();
            lin_mode   = 1'b1;
            k1         = 31'd3276800;
            k2         = 31'd819200;
            g          = 31'd65536;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEPTH_MODE: lin_mode = data[0];
                CFG_LOG_OFFSET: k1 = data;
                CFG_LOG_GAIN:   k2 = data;
                CFG_LIN_GAIN:   g = data;
                default: ;
            endcase
        endfunction

        function bit [63:0] mul_shr(bit [63:0] a, bit [63:0] b, int sh);
            bit [127:0] pr;
            pr = {64'd0, a} * {64'd0, b};
            pr = pr >> sh;
            return pr[63:0];
        endfunction

        function longint log2_fix(bit [63:0] v);
            int        p;
            bit [63:0] m;
            bit [63:0] fr;
            p  = 0;
            fr = 0;
            while (p < 63 && (v >> (p + 1)) != 0) p++;
            m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
            for (int i = 0; i < ITER_N; i++) begin
                m  = (m * m) >> 30;
                fr = fr << 1;
                if (m >= (64'd1 << 31)) begin
                    m     = m >> 1;
                    fr[0] = 1'b1;
                end
            end
            fr = fr << (32 - ITER_N);
            return longint'((64'(p) << 32) | fr);
        endfunction

        function bit [63:0] exp_fix(bit [63:0] u);
            bit [63:0] term;
            bit [63:0] sum;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (int k = 1; k <= ITER_N; k++) begin
                term = ((term * u) >> 30) / 64'(k);
                sum  = sum + term;
            end
            return sum;
        endfunction

        function bit [31:0] clip(bit neg, bit [63:0] mag, inout bit err);
            if (neg) begin
                if (mag > 64'd2147483648) begin
                    err = 1'b1;
                    return INT_MIN;
                end
                return ~mag[31:0] + 32'd1;
            end
            if (mag > 64'd2147483647) begin
                err = 1'b1;
                return INT_MAX;
            end
            return mag[31:0];
        endfunction

        function bit [31:0] log_fwd(longint d, inout bit err);
            longint    x;
            longint    diff;
            bit [63:0] ad;
            bit [63:0] lnq;
            x = d + longint'(k1);
            if (x <= 0) begin
                err = 1'b1;
                return INT_MAX;
            end
            diff = log2_fix(64'(x)) - log2_fix(64'(k1));
            ad   = (diff < 0) ? 64'(-diff) : 64'(diff);
            lnq  = mul_shr(ad, 64'(LN2_Q32), 32);
            return clip(diff > 0, mul_shr(lnq, 64'(k2), 32), err);
        endfunction

        function bit [31:0] log_inv(longint s, inout bit err);
            bit        rneg;
            bit [63:0] as_mag;
            bit [63:0] rm;
            bit [63:0] zm;
            bit [63:0] f;
            bit [63:0] ipm;
            bit [63:0] p;
            bit [63:0] val;
            longint    ip;
            int        sh;
            rneg   = s > 0;
            as_mag = (s < 0) ? 64'(-s) : 64'(s);
            rm     = (as_mag << 32) / 64'(k2);
            if (rm > (64'd64 << 32)) rm = 64'd64 << 32;
            zm  = mul_shr(rm, 64'(LOG2E_Q32), 32);
            ipm = zm >> 32;
            f   = {32'd0, zm[31:0]};
            if (!rneg || zm == 0) begin
                ip = longint'(ipm);
            end else if (f == 0) begin
                ip = -longint'(ipm);
            end else begin
                ip = -longint'(ipm) - 1;
                f  = (64'd1 << 32) - f;
            end
            if (ip >= 33) begin
                err = 1'b1;
                return INT_MAX;
            end
            p  = 64'(k1) * exp_fix(mul_shr(f, 64'(LN2_Q32), 34));
            sh = 30 - int'(ip);
            if (sh <= 0) val = p << (-sh);
            else if (sh >= 64) val = 0;
            else val = p >> sh;
            if (val >= 64'(k1)) return clip(1'b0, val - 64'(k1), err);
            return clip(1'b1, 64'(k1) - val, err);
        endfunction

        function void note_item(bit inv, bit [31:0] vin);
            longint    v;
            bit [63:0] av;
            bit        err;
            bit [31:0] r;
            err = 1'b0;
            v   = longint'($signed(vin));
            av  = (v < 0) ? 64'(-v) : 64'(v);
            if (!lin_mode) begin
                if (k1 == 0 || k2 == 0) begin
                    err = 1'b1;
                    r   = 0;
                end else begin
                    r = inv ? log_inv(v, err) : log_fwd(v, err);
                end
            end else if (g == 0) begin
                err = 1'b1;
                r   = 0;
            end else if (inv) begin
                r = clip(v > 0, (av << 16) / 64'(g), err);
            end else begin
                r = clip(v > 0, (av * 64'(g)) >> 16, err);
            end
            pending_val.push_back(r);
            pending_err.push_back(err);
        endfunction

        function void check_result(bit [31:0] val, bit err);
            bit [31:0] ev;
            bit        ee;
            if (pending_val.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: value %h error %b", val, err);
                return;
            end
            ev = pending_val.pop_front();
            ee = pending_err.pop_front();
            if (ev !== val || ee !== err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected value %h error %b, got value %h error %b",
                             ev, ee, val, err);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    llds_in_if  req_if();
    llds_out_if rsp_if();

    log_linear_depth_scaler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    depth_scoreboard sb = new();
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return INT_MAX;
        if (x < -64'sd2147483648) return INT_MIN;
        return x[31:0];
    endfunction

    function automatic bit [31:0] rand_value(bit inv);
        longint span;
        longint base;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                span = inv ? longint'(sb.k2) * 40 : longint'(sb.k1) * 3;
                if (span > 64'sd2147483647) span = 64'sd2147483647;
                base = longint'($urandom_range(0, 32'(span)));
                return clamp32($urandom_range(0, 1) ? base : -base);
            end
            2: return clamp32(-longint'(sb.k1) + longint'($urandom_range(0, 1024)) - 512);
            default: begin
                base = longint'($urandom_range(0, 1 << 20));
                return clamp32($urandom_range(0, 1) ? base : -base);
            end
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(bit lin, logic [30:0] off, logic [30:0] lg, logic [30:0] gain);
        while (sb.pending_val.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
        cfg_write(CFG_DEPTH_MODE, {30'd0, lin});
        cfg_write(CFG_LOG_OFFSET, off);
        cfg_write(CFG_LOG_GAIN, lg);
        cfg_write(CFG_LIN_GAIN, gain);
    endtask

    task automatic send_item(bit inv, bit [31:0] val, int gap);
        @(negedge i_clk);
        req_if.valid    <= 1'b1;
        req_if.mode     <= inv;
        req_if.value_in <= val;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_item(inv, val);
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic random_phase(int count);
        bit inv;
        for (int n = 0; n < count; n++) begin
            inv = $urandom_range(0, 1);
            send_item(inv, rand_value(inv), (n == count - 1) ? 1 : pick_gap());
        end
    endtask

    initial begin
        int gap_left;
        int calm;
        rsp_if.ready <= 1'b0;
        gap_left = 0;
        calm     = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (gap_left > 0) begin
                rsp_if.ready <= 1'b0;
                gap_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (calm > 0) calm--;
                else if ($urandom_range(0, 99) < 3) calm = $urandom_range(50, 200);
                else gap_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.value_out, rsp_if.range_error);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending_val.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DEPTH_MODE;
        i_cfg_data      <= '0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= 1'b0;
        req_if.value_in <= '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(1'b0, 32'h0000_0000, 0);
        send_item(1'b0, 32'h7FFF_FFFF, 0);
        send_item(1'b0, 32'h8000_0000, 1);
        send_item(1'b1, 32'h7FFF_FFFF, 0);
        send_item(1'b1, 32'h8000_0000, 0);
        send_item(1'b1, 32'hFFFF_FFFF, 2);
        set_config(1'b1, 31'd65536, 31'd1, 31'd1);
        send_item(1'b1, 32'h7FFF_FFFF, 0);
        send_item(1'b0, 32'h7FFF_FFFF, 1);
        set_config(1'b1, REG_MAX, REG_MAX, REG_MAX);
        send_item(1'b0, 32'h8000_0000, 0);
        send_item(1'b1, 32'h0001_0000, 1);
        set_config(1'b0, 31'd3276800, 31'd819200, 31'd65536);
        send_item(1'b0, 32'h0000_0000, 0);
        send_item(1'b0, 32'hFFCE_0000, 0);
        send_item(1'b0, 32'hFFCE_0001, 0);
        send_item(1'b0, 32'h7FFF_FFFF, 0);
        send_item(1'b0, 32'h8000_0000, 0);
        send_item(1'b1, 32'h0000_0000, 0);
        send_item(1'b1, 32'h7FFF_FFFF, 0);
        send_item(1'b1, 32'h8000_0000, 1);
        set_config(1'b0, 31'd65536, 31'd1, 31'd65536);
        send_item(1'b1, 32'hFFFF_FFFF, 0);
        send_item(1'b0, 32'h0001_0000, 1);
        set_config(1'b0, REG_MAX, REG_MAX, 31'd65536);
        send_item(1'b1, 32'h8000_0000, 0);
        send_item(1'b0, 32'h7FFF_FFFF, 1);

        set_config(1'b1, 31'd3276800, 31'd819200, 31'd65536);
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        set_config(1'b1, 31'd3276800, 31'd819200, 31'd1);
        random_phase(PHASE_ITEMS);
        set_config(1'b1, 31'd3276800, 31'd819200, REG_MAX);
        random_phase(PHASE_ITEMS);
        set_config(1'b1, 31'd3276800, 31'd819200, 31'($urandom_range(1, 32'h7FFF_FFFF)));
        random_phase(PHASE_ITEMS);
        set_config(1'b0, 31'd3276800, 31'd819200, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_config(1'b0, 31'd65536, 31'd1, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_config(1'b0, REG_MAX, REG_MAX, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_config(1'b0, 31'd65536, REG_MAX, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_config(1'b0, REG_MAX, 31'd1, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_config(1'b0, 31'($urandom_range(65536, 32'h7FFF_FFFF)),
                   31'($urandom_range(1, 1 << 24)), 31'd65536);
        random_phase(PHASE_ITEMS);

        while (sb.pending_val.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_val.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/llds_pkg.sv
src/llds_in_if.sv
src/llds_out_if.sv
src/log_linear_depth_scaler.sv
src/llds_chk.sv
test/tb_log_linear_depth_scaler.sv
